FILE: sv/ccdc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and weight tables for the CPF/CNPJ check digit classifier.
// No dependencies; imported by every module of the block.
package ccdc_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned CountW = 4;
    localparam int unsigned DigitW = 4;
    localparam int unsigned SumW   = 10;
    localparam int unsigned Sum1W  = 9;

    localparam logic [CharW-1:0]  CharZero = 8'd48;
    localparam logic [CharW-1:0]  CharNine = 8'd57;
    localparam logic [CountW-1:0] CountMax = 4'd15;
    localparam logic [CountW-1:0] LenCpf   = 4'd11;
    localparam logic [CountW-1:0] LenCnpj  = 4'd14;

    localparam logic [CountW-1:0] PosCpfChk1  = 4'd9;
    localparam logic [CountW-1:0] PosCpfChk2  = 4'd10;
    localparam logic [CountW-1:0] PosCnpjChk1 = 4'd12;
    localparam logic [CountW-1:0] PosCnpjChk2 = 4'd13;

    typedef enum logic [1:0] {
        CLS_INVALID = 2'd0,
        CLS_CPF     = 2'd1,
        CLS_CNPJ    = 2'd2
    } t_id_class;

    // Snapshot of one finished string, handed from the accumulator to the classifier.
    typedef struct packed {
        logic [CountW-1:0] count;
        logic [Sum1W-1:0]  cpf_sum1;
        logic [SumW-1:0]   cpf_sum2;
        logic [SumW-1:0]   cnpj_sum1;
        logic [SumW-1:0]   cnpj_sum2;
        logic              all_same;
        logic              bad_char;
        logic [DigitW-1:0] chk_cpf1;
        logic [DigitW-1:0] chk_cpf2;
        logic [DigitW-1:0] chk_cnpj1;
        logic [DigitW-1:0] chk_cnpj2;
    } t_frame;

    // Position weights; zero past the end of each sum.
    function automatic logic [DigitW-1:0] cpf_w1(input logic [CountW-1:0] pos);
        return (pos < 4'd9) ? 4'd10 - pos : 4'd0;
    endfunction

    function automatic logic [DigitW-1:0] cpf_w2(input logic [CountW-1:0] pos);
        return (pos < 4'd10) ? 4'd11 - pos : 4'd0;
    endfunction

    function automatic logic [DigitW-1:0] cnpj_w1(input logic [CountW-1:0] pos);
        logic [DigitW-1:0] w;
        if (pos < 4'd4) begin
            w = 4'd5 - pos;
        end else if (pos < 4'd12) begin
            w = 4'd13 - pos;
        end else begin
            w = 4'd0;
        end
        return w;
    endfunction

    function automatic logic [DigitW-1:0] cnpj_w2(input logic [CountW-1:0] pos);
        logic [DigitW-1:0] w;
        if (pos < 4'd5) begin
            w = 4'd6 - pos;
        end else if (pos < 4'd13) begin
            w = 4'd14 - pos;
        end else begin
            w = 4'd0;
        end
        return w;
    endfunction

endpackage

FILE: sv/cpf_cnpj_check_digit_classifier.sv
`timescale 1ns / 1ps
// Usage:
//   Slave stream carries an identifier string, one ASCII character per transfer in
//   i_s_tdata, with i_s_tlast high on its final character. Master stream carries
//   one result per string in o_m_tdata[1:0]: 0 invalid, 1 valid CPF, 2 valid CNPJ.
//   Non-final characters give no result.
// Pipeline: input register -> per-character accumulator -> frame register ->
//   mod-11 classifier -> output register.
// Throughput: one character per cycle unless o_s_tready is low; the accumulator
//   adds one weighted digit to each running sum per accepted character and a
//   string's sums are snapshotted into the frame register on its last character.
// Reset (i_rst_n low, synchronous): all stages empty, sums cleared, start of a
//   new string expected.
// Stall: when i_m_tready is low the output register holds its result; the frame
//   register and input register fill behind it. Non-final characters keep
//   flowing into the accumulator; a final character waits in the input register
//   until the frame register has room, and o_s_tready drops then.
// Depends on ccdc_pkg, ccdc_accum and ccdc_classify.
module cpf_cnpj_check_digit_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_code
    input  logic       i_s_tlast,   // last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [1:0] id_class, [7:2] zero
);
    import ccdc_pkg::*;

    // Input register
    logic             r_in_valid;
    logic [CharW-1:0] r_in_char;
    logic             r_in_last;

    // Frame register (one finished string)
    logic   r_frm_valid;
    t_frame r_frm;
    t_frame acc_frame;

    // Output register
    logic      r_out_valid;
    t_id_class r_out_class;
    t_id_class cls;

    logic out_free, frm_free, in_take;

    assign out_free   = !r_out_valid || i_m_tready;
    assign frm_free   = !r_frm_valid || out_free;
    // Only a final character needs room downstream.
    assign in_take    = r_in_valid && (!r_in_last || frm_free);
    assign o_s_tready = !r_in_valid || in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    ccdc_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_take),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_frame (acc_frame)
    );

    // Capture the completed string on its last character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm_valid <= 1'b0;
        end else if (frm_free) begin
            r_frm_valid <= in_take && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frm_free && in_take && r_in_last) begin
            r_frm <= acc_frame;
        end
    end

    ccdc_classify u_classify (
        .i_frame (r_frm),
        .o_class (cls)
    );

    // Output register: hold while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_frm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_frm_valid) begin
            r_out_class <= cls;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_class};

endmodule

FILE: sv/ccdc_accum.sv
`timescale 1ns / 1ps
// Per-character accumulator: weighted digit sums, length, repeat and bad-character flags.
// Depends on ccdc_pkg.
module ccdc_accum (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [ccdc_pkg::CharW-1:0] i_char,
    input  logic                   i_last,
    output ccdc_pkg::t_frame       o_frame
);
    import ccdc_pkg::*;

    logic [CountW-1:0] r_count;
    logic [Sum1W-1:0]  r_cpf_sum1;
    logic [SumW-1:0]   r_cpf_sum2;
    logic [SumW-1:0]   r_cnpj_sum1;
    logic [SumW-1:0]   r_cnpj_sum2;
    logic [CharW-1:0]  r_first;
    logic              r_all_same;
    logic              r_bad_char;
    logic [DigitW-1:0] r_chk [4];

    logic              is_digit;
    logic [DigitW-1:0] dig;
    logic [7:0]        p_cpf1, p_cpf2, p_cnpj1, p_cnpj2;
    t_frame            n_frame;
    logic [CharW-1:0]  n_first;

    assign is_digit = (i_char >= CharZero) && (i_char <= CharNine);
    assign dig      = is_digit ? DigitW'(i_char - CharZero) : '0;

    assign p_cpf1  = {4'd0, dig} * {4'd0, cpf_w1(r_count)};
    assign p_cpf2  = {4'd0, dig} * {4'd0, cpf_w2(r_count)};
    assign p_cnpj1 = {4'd0, dig} * {4'd0, cnpj_w1(r_count)};
    assign p_cnpj2 = {4'd0, dig} * {4'd0, cnpj_w2(r_count)};

    always_comb begin
        n_frame.count     = (r_count < CountMax) ? r_count + 4'd1 : r_count;
        n_frame.cpf_sum1  = r_cpf_sum1 + {1'b0, p_cpf1};
        n_frame.cpf_sum2  = r_cpf_sum2 + {2'b0, p_cpf2};
        n_frame.cnpj_sum1 = r_cnpj_sum1 + {2'b0, p_cnpj1};
        n_frame.cnpj_sum2 = r_cnpj_sum2 + {2'b0, p_cnpj2};
        n_frame.bad_char  = r_bad_char | ~is_digit;
        n_frame.all_same  = r_all_same;
        n_first           = r_first;
        if (r_count == '0) begin
            n_first = i_char;
        end else if ((r_count <= PosCpfChk2) && (i_char != r_first)) begin
            n_frame.all_same = 1'b0;
        end
        n_frame.chk_cpf1  = (r_count == PosCpfChk1)  ? dig : r_chk[0];
        n_frame.chk_cpf2  = (r_count == PosCpfChk2)  ? dig : r_chk[1];
        n_frame.chk_cnpj1 = (r_count == PosCnpjChk1) ? dig : r_chk[2];
        n_frame.chk_cnpj2 = (r_count == PosCnpjChk2) ? dig : r_chk[3];
    end

    assign o_frame = n_frame;

    // Advance on every character; clear back to the start state after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_last)) begin
            r_count     <= '0;
            r_cpf_sum1  <= '0;
            r_cpf_sum2  <= '0;
            r_cnpj_sum1 <= '0;
            r_cnpj_sum2 <= '0;
            r_first     <= '0;
            r_all_same  <= 1'b1;
            r_bad_char  <= 1'b0;
            r_chk[0]    <= '0;
            r_chk[1]    <= '0;
            r_chk[2]    <= '0;
            r_chk[3]    <= '0;
        end else if (i_valid) begin
            r_count     <= n_frame.count;
            r_cpf_sum1  <= n_frame.cpf_sum1;
            r_cpf_sum2  <= n_frame.cpf_sum2;
            r_cnpj_sum1 <= n_frame.cnpj_sum1;
            r_cnpj_sum2 <= n_frame.cnpj_sum2;
            r_first     <= n_first;
            r_all_same  <= n_frame.all_same;
            r_bad_char  <= n_frame.bad_char;
            r_chk[0]    <= n_frame.chk_cpf1;
            r_chk[1]    <= n_frame.chk_cpf2;
            r_chk[2]    <= n_frame.chk_cnpj1;
            r_chk[3]    <= n_frame.chk_cnpj2;
        end
    end

endmodule

FILE: sv/ccdc_classify.sv
`timescale 1ns / 1ps
// Final classification: mod-11 check digits of the four sums, length and flag checks.
// Depends on ccdc_pkg; pure combinational.
module ccdc_classify (
    input  ccdc_pkg::t_frame    i_frame,
    output ccdc_pkg::t_id_class o_class
);
    import ccdc_pkg::*;

    // x mod 11 through a reciprocal estimate that is low by at most one, then
    // fold the remainder once; result mapped to the check digit.
    function automatic logic [DigitW-1:0] mod11_digit(input logic [SumW-1:0] x);
        logic [17:0]     prod;
        logic [6:0]      q;
        logic [SumW-1:0] q11;
        logic [4:0]      r;
        logic [3:0]      rm;
        prod = {8'd0, x} * 18'd186;
        q    = prod[17:11];
        q11  = SumW'({3'd0, q} * 10'd11);
        r    = 5'(x - q11);
        rm   = (r >= 5'd11) ? 4'(r - 5'd11) : r[3:0];
        return (rm < 4'd2) ? 4'd0 : 4'd11 - rm;
    endfunction

    logic cpf_ok, cnpj_ok;

    assign cpf_ok  = !i_frame.all_same
                  && (i_frame.chk_cpf1 == mod11_digit({1'b0, i_frame.cpf_sum1}))
                  && (i_frame.chk_cpf2 == mod11_digit(i_frame.cpf_sum2));
    assign cnpj_ok = (i_frame.chk_cnpj1 == mod11_digit(i_frame.cnpj_sum1))
                  && (i_frame.chk_cnpj2 == mod11_digit(i_frame.cnpj_sum2));

    always_comb begin
        o_class = CLS_INVALID;
        if (!i_frame.bad_char) begin
            if (i_frame.count == LenCpf && cpf_ok) begin
                o_class = CLS_CPF;
            end else if (i_frame.count == LenCnpj && cnpj_ok) begin
                o_class = CLS_CNPJ;
            end
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for cpf_cnpj_check_digit_classifier: streams identifier strings in and
// checks each string's class against a cycle-free model of the mod-11 rules.
// Depends on ccdc_pkg and the block's RTL only.
module tb_top;
    import ccdc_pkg::*;

    localparam int unsigned IdleLimit = 2000;   // cycles with no transfer before giving up
    localparam int unsigned DrainCycles = 8;    // wait after every class has come back, before finishing
    localparam int unsigned CharTarget = 1050;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'd0;  // [7:0] char_code
    logic       i_s_tlast = 1'b0;  // last
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;         // [1:0] id_class, [7:2] zero

    cpf_cnpj_check_digit_classifier u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // One character on the input stream; a pinned class rides on the final character
    // of a directed string whose answer is obvious.
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       has_cls;
        t_id_class  cls;
    } t_char_item;

    typedef struct {
        string     txt;
        logic      has_cls;
        t_id_class cls;
    } t_id_row;

    // Directed strings. '#' stands for a NUL byte, which a string literal cannot carry.
    t_id_row id_table [12] = '{
        '{"52998224725",       1'b0, CLS_INVALID},  // well-formed CPF
        '{"11222333000181",    1'b0, CLS_INVALID},  // well-formed CNPJ
        '{"11111111111",       1'b1, CLS_INVALID},  // repeated CPF digits, checks would pass
        '{"00000000000000",    1'b1, CLS_CNPJ},     // repeated CNPJ digits are fine
        '{"5299822472#",       1'b1, CLS_INVALID},  // NUL byte in place of a digit
        '{"\377",              1'b1, CLS_INVALID},  // single character, top code
        '{"9",                 1'b1, CLS_INVALID},  // single digit
        '{"/2998224725",       1'b1, CLS_INVALID},  // just below '0'
        '{"1122233300018:",    1'b1, CLS_INVALID},  // just above '9'
        '{"529982247250",      1'b1, CLS_INVALID},  // twelve digits
        '{"112223330001810",   1'b1, CLS_INVALID},  // fifteen digits
        '{"11222333000181999", 1'b1, CLS_INVALID}   // count saturates, still invalid
    };

    t_char_item char_q[$];         // characters waiting to be driven
    t_id_class  pending_class_q[$]; // classes owed by the block, oldest first
    logic [7:0] id_buf[$];         // scratch string while building stimulus
    t_char_item drv_item;          // character currently on the input bus
    logic       in_xfer = 1'b0;    // input transfer at the last rising edge
    int         chars_sent = 0;
    int         fail_cnt = 0;
    int unsigned idle_cycles = 0;

    // Hold both sides busy for a long stretch in the middle of the random part.
    wire calm_window = (chars_sent >= 400) && (chars_sent < 700);

    // Running tally of the string being classified.
    logic [CountW-1:0] tally_count;
    logic [Sum1W-1:0]  tally_cpf1;
    logic [SumW-1:0]   tally_cpf2;
    logic [SumW-1:0]   tally_cnpj1;
    logic [SumW-1:0]   tally_cnpj2;
    logic [CharW-1:0]  tally_first;
    logic              tally_same;
    logic              tally_bad;
    logic [DigitW-1:0] tally_chk [4];

    // Weight of position pos in a sum over span positions. Both schemes count down to 2
    // from the last position; CNPJ wraps back to 9 after reaching 2.
    function automatic int unsigned scheme_weight(input logic cnpj, input int unsigned pos,
                                                  input int unsigned span);
        int unsigned w;
        if (pos >= span) begin
            return 0;
        end
        w = span + 1 - pos;
        if (cnpj && w > 9) begin
            w -= 8;
        end
        return w;
    endfunction

    function automatic logic [DigitW-1:0] mod11_check(input int unsigned total);
        int unsigned r;
        r = total % 11;
        return (r < 2) ? 4'd0 : 4'(11 - r);
    endfunction

    function automatic void clear_tally();
        tally_count = '0;
        tally_cpf1  = '0;
        tally_cpf2  = '0;
        tally_cnpj1 = '0;
        tally_cnpj2 = '0;
        tally_first = '0;
        tally_same  = 1'b1;
        tally_bad   = 1'b0;
        for (int k = 0; k < 4; k++) begin
            tally_chk[k] = '0;
        end
    endfunction

    // Fold one accepted character into the tally; on the final character return 1 with
    // the string's class and start over.
    function automatic logic absorb_char(input logic [7:0] ch, input logic last,
                                         output t_id_class cls);
        logic              is_digit;
        logic [DigitW-1:0] dig;
        is_digit = (ch >= CharZero) && (ch <= CharNine);
        dig = is_digit ? DigitW'(ch - CharZero) : '0;
        cls = CLS_INVALID;
        if (!is_digit) begin
            tally_bad = 1'b1;
        end
        if (tally_count == 0) begin
            tally_first = ch;
        end else if (tally_count <= PosCpfChk2 && ch != tally_first) begin
            tally_same = 1'b0;
        end
        tally_cpf1  = tally_cpf1  + Sum1W'(dig * scheme_weight(1'b0, tally_count, 9));
        tally_cpf2  = tally_cpf2  + SumW'(dig * scheme_weight(1'b0, tally_count, 10));
        tally_cnpj1 = tally_cnpj1 + SumW'(dig * scheme_weight(1'b1, tally_count, 12));
        tally_cnpj2 = tally_cnpj2 + SumW'(dig * scheme_weight(1'b1, tally_count, 13));
        case (tally_count)
            PosCpfChk1:  tally_chk[0] = dig;
            PosCpfChk2:  tally_chk[1] = dig;
            PosCnpjChk1: tally_chk[2] = dig;
            PosCnpjChk2: tally_chk[3] = dig;
            default: ;
        endcase
        if (tally_count != CountMax) begin
            tally_count++;
        end
        if (!last) begin
            return 1'b0;
        end
        if (!tally_bad) begin
            if (tally_count == LenCpf) begin
                if (!tally_same && tally_chk[0] == mod11_check(tally_cpf1)
                        && tally_chk[1] == mod11_check(tally_cpf2)) begin
                    cls = CLS_CPF;
                end
            end else if (tally_count == LenCnpj) begin
                if (tally_chk[2] == mod11_check(tally_cnpj1)
                        && tally_chk[3] == mod11_check(tally_cnpj2)) begin
                    cls = CLS_CNPJ;
                end
            end
        end
        clear_tally();
        return 1'b1;
    endfunction

    function automatic logic [7:0] random_digit();
        return CharZero + 8'($urandom_range(9));
    endfunction

    // Weighted sum of the first span digits in the scratch string.
    function automatic int unsigned weighted_sum(input logic cnpj, input int unsigned span);
        int unsigned total;
        total = 0;
        for (int unsigned k = 0; k < span; k++) begin
            total += (id_buf[k] - CharZero) * scheme_weight(cnpj, k, span);
        end
        return total;
    endfunction

    // Move the scratch string onto the drive queue, flagging its final character.
    task automatic push_id(input logic has_cls, input t_id_class cls);
        t_char_item it;
        for (int k = 0; k < id_buf.size(); k++) begin
            it.ch      = id_buf[k];
            it.last    = (k == id_buf.size() - 1);
            it.has_cls = has_cls && it.last;
            it.cls     = cls;
            char_q.push_back(it);
        end
    endtask

    // Build one random string: mostly well-formed CPF or CNPJ (some damaged), then
    // repeated digits, digit strings of any length, and raw byte noise.
    task automatic queue_random_id();
        int unsigned pick;
        int unsigned len;
        int unsigned spot;
        logic        cnpj;
        logic [7:0]  ch;
        id_buf.delete();
        pick = $urandom_range(99);
        if (pick < 60) begin
            cnpj = (pick >= 30);
            len = cnpj ? 12 : 9;
            repeat (len) id_buf.push_back(random_digit());
            id_buf.push_back(CharZero + 8'(mod11_check(weighted_sum(cnpj, len))));
            id_buf.push_back(CharZero + 8'(mod11_check(weighted_sum(cnpj, len + 1))));
            if ($urandom_range(99) < 40) begin
                spot = $urandom_range(id_buf.size() - 1);
                case ($urandom_range(3))
                    0: id_buf[spot] = random_digit();
                    1: id_buf[spot] = 8'($urandom_range(255));
                    2: id_buf.push_back(random_digit());
                    default: id_buf.delete(spot);
                endcase
            end
        end else if (pick < 68) begin
            ch = random_digit();
            len = ($urandom_range(3) == 0) ? 14 : 11;
            repeat (len) id_buf.push_back(ch);
        end else if (pick < 84) begin
            len = $urandom_range(18, 1);
            repeat (len) id_buf.push_back(random_digit());
        end else begin
            len = $urandom_range(16, 1);
            repeat (len) id_buf.push_back(8'($urandom_range(255)));
        end
        push_id(1'b0, CLS_INVALID);
    endtask

    // Input side: advance to the next character once the current one has transferred,
    // or drop tvalid and sit idle.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || in_xfer)) begin
            if (char_q.size() != 0 && (calm_window || $urandom_range(99) >= 34)) begin
                drv_item = char_q.pop_front();
                chars_sent++;
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= drv_item.ch;
                i_s_tlast  <= drv_item.last;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: stall at random outside the calm stretch.
    always @(negedge i_clk) begin
        i_m_tready <= calm_window || ($urandom_range(99) >= 34);
    end

    // Predict on every input transfer, check every output transfer.
    always @(posedge i_clk) begin : monitor
        t_id_class want;
        in_xfer = i_rst_n && i_s_tvalid && o_s_tready;
        if (in_xfer) begin
            if (absorb_char(i_s_tdata, i_s_tlast, want)) begin
                pending_class_q.push_back(drv_item.has_cls ? drv_item.cls : want);
            end
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_class_q.size() == 0) begin
                $error("id_class: no string pending, actual %0d", o_m_tdata[1:0]);
                fail_cnt++;
            end else begin
                want = pending_class_q.pop_front();
                if (o_m_tdata[1:0] !== want) begin
                    $error("id_class mismatch: expected %0d, actual %0d", want, o_m_tdata[1:0]);
                    fail_cnt++;
                end
                if (o_m_tdata[7:2] !== 6'd0) begin
                    $error("tdata pad mismatch: expected 0, actual %0d", o_m_tdata[7:2]);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: give up when neither stream moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IdleLimit) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        logic [7:0] ch;
        clear_tally();
        // Directed table first, then random strings until the character budget is spent.
        foreach (id_table[r]) begin
            id_buf.delete();
            for (int k = 0; k < id_table[r].txt.len(); k++) begin
                ch = id_table[r].txt[k];
                id_buf.push_back((ch == "#") ? 8'd0 : ch);
            end
            push_id(id_table[r].has_cls, id_table[r].cls);
        end
        while (char_q.size() < CharTarget) begin
            queue_random_id();
        end

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Hold until every character has transferred and every class has come back.
        while (char_q.size() != 0 || i_s_tvalid || pending_class_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DrainCycles) @(negedge i_clk);

        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
